>>> hw/rtl/assert_macros.svh
// assertion macros used by the servo command formatter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

>>> hw/rtl/scaf_pkg.sv
// types, command codes and character codes for the servo command formatter
package scaf_pkg;

   // input transaction
   typedef struct packed {
      logic        command;
      logic [4:0]  channel;
      logic [15:0] pulse_us;
      logic [15:0] speed;
      logic [15:0] move_time;
   } req_type;

   // output transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   localparam int MAX_DIGITS_DEFAULT = 5;
   localparam int VAL_W              = 16;

   // command codes
   localparam logic CMD_MOVE    = 1'b0;
   localparam logic CMD_EXECUTE = 1'b1;

   // ascii characters
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_T    = 8'h54;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_ZERO = 8'h30;

   // reciprocal of ten, exact for 16-bit values after a shift of 19
   localparam logic [16:0] RECIP10       = 17'd52429;
   localparam int          RECIP10_SHIFT = 19;

endpackage

>>> hw/rtl/scaf_div10.sv
// shared divide-by-ten unit: quotient and remainder of a 16-bit value
module scaf_div10 (
   input  logic [scaf_pkg::VAL_W-1:0] value,
   output logic [scaf_pkg::VAL_W-1:0] quotient,
   output logic [3:0]                 remainder
);

   localparam int PROD_W = scaf_pkg::VAL_W + 17;

   logic [PROD_W-1:0]         prod;
   logic [scaf_pkg::VAL_W-1:0] q;
   logic [scaf_pkg::VAL_W-1:0] q_times10;
   logic [scaf_pkg::VAL_W-1:0] diff;

   // reciprocal multiply gives the quotient
   assign prod = PROD_W'(value) * PROD_W'(scaf_pkg::RECIP10);
   assign q    = scaf_pkg::VAL_W'(prod >> scaf_pkg::RECIP10_SHIFT);

   // remainder by shift-add back-multiply and subtract
   assign q_times10 = (q << 3) + (q << 1);
   assign diff      = value - q_times10;

   assign quotient  = q;
   assign remainder = diff[3:0];

endmodule

>>> hw/rtl/servo_command_ascii_formatter.sv
// Servo command formatter: a move transaction becomes '#'ch 'P'pw ['S'sp] ['T'tm] bytes.
// The first byte is registered into the output register by the tag state that follows acceptance.
// Each field emits its tag, converts one digit at a time in the shared divide-by-ten unit,
// then emits the digits most significant first, up to MAX_DIGITS digits per field.
// An execute transaction gives one carriage return. Output stalls hold the emitting states.
// Synchronous reset clears the sequencer and the output valid; the payload registers are not reset.
`include "assert_macros.svh"

module servo_command_ascii_formatter #(
   parameter int MAX_DIGITS = scaf_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scaf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scaf_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int VAL_W = scaf_pkg::VAL_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TAG  = 3'd1;
   localparam logic [2:0] ST_CONV = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [2:0] ST_CR   = 3'd4;

   // field codes
   localparam logic [1:0] FLD_CHAN  = 2'd0;
   localparam logic [1:0] FLD_PULSE = 2'd1;
   localparam logic [1:0] FLD_SPEED = 2'd2;
   localparam logic [1:0] FLD_TIME  = 2'd3;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        field_ff, field_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   scaf_pkg::req_type item_ff, item_in;
   logic [3:0]        digit_ff [MAX_DIGITS];
   logic              rsp_valid_ff, rsp_valid_in;
   scaf_pkg::rsp_type rsp_ff, rsp_in;

   logic              req_fire;
   logic              out_free;
   logic              emit;
   logic              digit_we;
   logic [CNT_W-1:0]  cnt_dec;
   logic [VAL_W-1:0]  quotient;
   logic [3:0]        remainder;
   logic [VAL_W-1:0]  field_val;
   logic [7:0]        field_tag;
   logic              field_final;
   logic [1:0]        field_next;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cnt_dec   = cnt_ff - 1'b1;

   // shared divide-by-ten unit
   scaf_div10 u_div10 (
      .value     (val_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // value and tag of the current field
   always_comb begin
      case (field_ff)
         FLD_CHAN: begin
            field_val = VAL_W'(item_ff.channel);
            field_tag = scaf_pkg::CH_HASH;
         end
         FLD_PULSE: begin
            field_val = item_ff.pulse_us;
            field_tag = scaf_pkg::CH_P;
         end
         FLD_SPEED: begin
            field_val = item_ff.speed;
            field_tag = scaf_pkg::CH_S;
         end
         default: begin
            field_val = item_ff.move_time;
            field_tag = scaf_pkg::CH_T;
         end
      endcase
   end

   // which field follows, skipping zero speed and time
   always_comb begin
      field_final = 1'b0;
      field_next  = field_ff;
      case (field_ff)
         FLD_CHAN: begin
            field_next = FLD_PULSE;
         end
         FLD_PULSE: begin
            if (item_ff.speed != '0) begin
               field_next = FLD_SPEED;
            end else if (item_ff.move_time != '0) begin
               field_next = FLD_TIME;
            end else begin
               field_final = 1'b1;
            end
         end
         FLD_SPEED: begin
            if (item_ff.move_time != '0) begin
               field_next = FLD_TIME;
            end else begin
               field_final = 1'b1;
            end
         end
         default: begin
            field_final = 1'b1;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      field_in = field_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      item_in  = item_ff;
      emit     = 1'b0;
      digit_we = 1'b0;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in  = req_data;
               field_in = FLD_CHAN;
               if (req_data.command == scaf_pkg::CMD_EXECUTE) begin
                  state_in = ST_CR;
               end else begin
                  state_in = ST_TAG;
               end
            end
         end
         ST_TAG: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_in.out_byte = field_tag;
               rsp_in.last     = 1'b0;
               val_in          = field_val;
               cnt_in          = '0;
               state_in        = ST_CONV;
            end
         end
         ST_CONV: begin
            digit_we = 1'b1;
            val_in   = quotient;
            cnt_in   = cnt_ff + 1'b1;
            if (quotient == '0 || cnt_ff == CNT_W'(MAX_DIGITS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_in.out_byte = scaf_pkg::CH_ZERO + 8'(digit_ff[cnt_dec[IDX_W-1:0]]);
               rsp_in.last     = 1'b0;
               cnt_in          = cnt_dec;
               if (cnt_ff == CNT_W'(1)) begin
                  if (field_final) begin
                     rsp_in.last = 1'b1;
                     state_in    = ST_IDLE;
                  end else begin
                     field_in = field_next;
                     state_in = ST_TAG;
                  end
               end
            end
         end
         ST_CR: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_in.out_byte = scaf_pkg::CH_CR;
               rsp_in.last     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      field_ff <= field_in;
      cnt_ff   <= cnt_in;
      val_ff   <= val_in;
      item_ff  <= item_in;
      rsp_ff   <= rsp_in;
      if (digit_we) begin
         digit_ff[cnt_ff[IDX_W-1:0]] <= remainder;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks on the sequencer
   `ASSERT_PROP(a_emit_has_digit, clock, reset, (state_ff == ST_EMIT) |-> (cnt_ff != '0), "emit state with no digit left")
   `ASSERT_NEVER(a_cnt_range, clock, reset, (state_ff == ST_CONV) && (cnt_ff >= CNT_W'(MAX_DIGITS)), "digit count overflow")
   `ASSERT_PROP(a_accept_leaves_idle, clock, reset, req_fire |=> (state_ff != ST_IDLE), "accepted transaction left sequencer idle")
   `ASSERT_PROP(a_execute_to_cr, clock, reset, (req_fire && req_data.command == scaf_pkg::CMD_EXECUTE) |=> (state_ff == ST_CR), "execute transaction not sent to carriage return")

endmodule

>>> test/servo_command_ascii_formatter_tb.sv
// self-checking testbench for the servo command ascii formatter
module servo_command_ascii_formatter_tb;

   localparam int          STALL_LIMIT = 2000;
   localparam int          SETTLE_CYCLES = 60;
   localparam int          RANDOM_ITEMS = 200;
   localparam logic [15:0] DEC_BASE = 16'd10;

   // scoreboard: predicts the command text and checks each output byte in order
   class servo_text_scoreboard;
      scaf_pkg::rsp_type pending_text[$];
      int unsigned       mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      function int unsigned pending();
         return pending_text.size();
      endfunction

      function void push_char(logic [7:0] ch);
         pending_text.push_back(scaf_pkg::rsp_type'{out_byte: ch, last: 1'b0});
      endfunction

      // tag character, then the value in decimal without leading zeros
      function void push_field(logic [7:0] tag, logic [15:0] value);
         logic [7:0]  digits[$];
         logic [15:0] rest;
         push_char(tag);
         rest = value;
         if (rest == 16'd0) begin
            digits.push_front(scaf_pkg::CH_ZERO);
         end
         while (rest != 16'd0) begin
            digits.push_front(scaf_pkg::CH_ZERO + 8'(rest % DEC_BASE));
            rest = rest / DEC_BASE;
         end
         foreach (digits[i]) push_char(digits[i]);
      endfunction

      // accepted command transaction: queue its whole text, last flag on the final byte
      function void note_command(scaf_pkg::req_type cmd);
         if (cmd.command == scaf_pkg::CMD_EXECUTE) begin
            push_char(scaf_pkg::CH_CR);
         end else begin
            push_field(scaf_pkg::CH_HASH, {11'd0, cmd.channel});
            push_field(scaf_pkg::CH_P, cmd.pulse_us);
            if (cmd.speed != 16'd0) push_field(scaf_pkg::CH_S, cmd.speed);
            if (cmd.move_time != 16'd0) push_field(scaf_pkg::CH_T, cmd.move_time);
         end
         pending_text[pending_text.size() - 1].last = 1'b1;
      endfunction

      // accepted byte transaction: compare against the oldest predicted byte
      function void check_byte(scaf_pkg::rsp_type got);
         scaf_pkg::rsp_type want;
         if (pending_text.size() == 0) begin
            $error("unexpected byte: out_byte=%02h last=%0b", got.out_byte, got.last);
            mismatch_count++;
            return;
         end
         want = pending_text.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
            mismatch_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            mismatch_count++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   scaf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   scaf_pkg::rsp_type rsp_data;

   servo_text_scoreboard sb;
   bit                   tx_steady = 1'b0;
   bit                   rx_steady = 1'b0;
   int unsigned          quiet_cycles = 0;

   servo_command_ascii_formatter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_command(req_data);
         if (rsp_valid && rsp_ready) sb.check_byte(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // byte sink with random stalls, sometimes in steady stretches
   always begin : drain_bytes
      int unsigned stall;
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
         @(negedge clock);
         rsp_ready <= 1'b0;
      end
      @(negedge clock);
      rsp_ready <= 1'b1;
      do @(posedge clock); while (!(rsp_valid && rsp_ready));
   end

   // present one command after a random gap and hold it until accepted
   task automatic send_command(input scaf_pkg::req_type cmd);
      int unsigned gap;
      gap = tx_steady ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending until every predicted byte has come out
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic scaf_pkg::req_type move_cmd(logic [4:0] ch, logic [15:0] pw,
                                                  logic [15:0] sp, logic [15:0] tm);
      return scaf_pkg::req_type'{command: scaf_pkg::CMD_MOVE, channel: ch, pulse_us: pw,
                                 speed: sp, move_time: tm};
   endfunction

   // execute with junk in the ignored fields
   function automatic scaf_pkg::req_type random_execute();
      return scaf_pkg::req_type'{command: scaf_pkg::CMD_EXECUTE, channel: 5'($urandom),
                                 pulse_us: 16'($urandom), speed: 16'($urandom),
                                 move_time: 16'($urandom)};
   endfunction

   // value spread over every digit count, plus full-range draws for bit coverage
   function automatic logic [15:0] random_value();
      case ($urandom_range(0, 6))
         0: return 16'd0;
         1: return 16'($urandom_range(1, 9));
         2: return 16'($urandom_range(10, 99));
         3: return 16'($urandom_range(100, 999));
         4: return 16'($urandom_range(1000, 9999));
         5: return 16'($urandom_range(10000, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic scaf_pkg::req_type random_move();
      logic [15:0] sp;
      logic [15:0] tm;
      sp = ($urandom_range(0, 3) == 0) ? 16'd0 : random_value();
      tm = ($urandom_range(0, 3) == 0) ? 16'd0 : random_value();
      return move_cmd(5'($urandom), random_value(), sp, tm);
   endfunction

   initial begin : stimulus
      int unsigned group_len;
      int unsigned sent;
      bit          paused;
      sb = new();
      sent   = 0;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: execute, zero values, digit-count boundaries, widest output
      send_command(scaf_pkg::req_type'{command: scaf_pkg::CMD_EXECUTE, channel: '0,
                                       pulse_us: '0, speed: '0, move_time: '0});
      send_command(scaf_pkg::req_type'{command: scaf_pkg::CMD_EXECUTE, channel: '1,
                                       pulse_us: '1, speed: '1, move_time: '1});
      send_command(move_cmd(5'd0, 16'd0, 16'd0, 16'd0));
      send_command(move_cmd(5'd31, 16'd65535, 16'd65535, 16'd65535));
      send_command(move_cmd(5'd9, 16'd9, 16'd0, 16'd9));
      send_command(move_cmd(5'd10, 16'd10, 16'd10, 16'd0));
      send_command(move_cmd(5'd1, 16'd99, 16'd100, 16'd999));
      send_command(move_cmd(5'd20, 16'd1000, 16'd9999, 16'd10000));
      send_command(move_cmd(5'd5, 16'd1500, 16'd1, 16'd0));
      send_command(move_cmd(5'd16, 16'd0, 16'd0, 16'd1));
      send_command(move_cmd(5'd21, 16'h5555, 16'hAAAA, 16'h8000));
      send_command(move_cmd(5'd10, 16'hAAAA, 16'h5555, 16'hFFFF));
      send_command(random_execute());
      hold_until_drained();

      // random: groups of moves closed by an execute, some groups left open
      while (sent < RANDOM_ITEMS) begin
         tx_steady = ($urandom_range(0, 3) == 0);
         group_len = $urandom_range(1, 6);
         repeat (group_len) begin
            send_command(random_move());
            sent++;
         end
         if ($urandom_range(0, 7) != 0) begin
            send_command(random_execute());
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end
      end
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
